[rtl/bb_pkg.sv]
// Shared types and constants of the 3x3 box blur block.
package bb_pkg;

  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int NUM_W      = 13;
  localparam int DEN_W      = 5;
  localparam int ROW_W      = 12;
  localparam int HEIGHT_MAX = 4096;
  localparam int CFGW_W     = 11;
  localparam int CFGH_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int JOBQ_DEPTH = 8;
  localparam int JOBQ_AW    = 3;
  localparam int JOBS_MAX   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [3*CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] count;
    logic             last;
  } job_t;

  typedef struct packed {
    logic             empty;
    logic [JOBQ_AW:0] level;
  } jobq_stat_t;

endpackage

[rtl/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB box blur.
//
//   channel  direction  handshake         payload
//   in       input      in_push/in_full   in_red, in_green, in_blue
//   out      output     out_pop/out_empty out_blur_red/green/blue, out_frame_last
//   cfg      input      cfg_wr_en         cfg_index, cfg_data
//
// Front end: each pixel passes intake, line-buffer update and four job slots before the next is taken.
// Back end: each result is loaded, divided in 13 steps and handed off; the divider
// sets the sustained rate, up to four results per pixel on the last row.
// Reset is synchronous; line buffers hold stale data, masked at frame edges.
// Intake stalls while the job queue holds more than four jobs; a held result stalls the divider directly.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [bb_pkg::CH_W-1:0]       in_red,
  input  logic [bb_pkg::CH_W-1:0]       in_green,
  input  logic [bb_pkg::CH_W-1:0]       in_blue,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bb_pkg::CH_W-1:0]       out_blur_red,
  output logic [bb_pkg::CH_W-1:0]       out_blur_green,
  output logic [bb_pkg::CH_W-1:0]       out_blur_blue,
  output logic                          out_frame_last,
  input  logic                          cfg_wr_en,
  input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bb_pkg::*;

  logic       job_push;
  job_t       job_in;
  job_t       job_out;
  logic       job_pop;
  jobq_stat_t q_stat;

  bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job_data  (job_in),
    .q_stat    (q_stat)
  );

  bb_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .stat  (q_stat)
  );

  bb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (job_out),
    .job_valid      (!q_stat.empty),
    .job_pop        (job_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_blur_red   (out_blur_red),
    .out_blur_green (out_blur_green),
    .out_blur_blue  (out_blur_blue),
    .out_frame_last (out_frame_last)
  );

endmodule

[rtl/bb_jobq.sv]
// Job queue between the window front end and the divider back end.
module bb_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bb_pkg::job_t      din,
  input  logic              pop,
  output bb_pkg::job_t      dout,
  output bb_pkg::jobq_stat_t stat
);
  import bb_pkg::*;

  job_t               mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wp_r;
  logic [JOBQ_AW-1:0] rp_r;
  logic [JOBQ_AW:0]   level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

endmodule

[rtl/bb_front.sv]
// Front end: pixel intake, line buffers, 3x3 window and job generation.
module bb_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [bb_pkg::CH_W-1:0]          in_red,
  input  logic [bb_pkg::CH_W-1:0]          in_green,
  input  logic [bb_pkg::CH_W-1:0]          in_blue,
  input  logic                             cfg_wr_en,
  input  logic [bb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                             job_push,
  output bb_pkg::job_t                     job_data,
  input  bb_pkg::jobq_stat_t               q_stat
);
  import bb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMP_W = 13;

  typedef enum logic [1:0] {F_IN, F_RD, F_EMIT} fstate_t;

  fstate_t             state_r;
  logic [CFGW_W-1:0]   width_r;
  logic [CFGH_W-1:0]   height_r;
  logic [CW-1:0]       col_r;
  logic [ROW_W-1:0]    row_r;
  logic [CW-1:0]       cur_c_r;
  logic [ROW_W-1:0]    cur_y_r;
  pixel_t              px_r;
  logic                end_row_r;
  logic                last_row_r;
  logic [1:0]          sel_r;
  pixel_t              win_r [3][3];
  pixel_t              up_q_r;
  pixel_t              mid_q_r;

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];

  logic [CMP_W-1:0] w_last;
  logic [CMP_W-1:0] h_last;
  logic             accept;
  logic             c_ge1, c_ge2, r_ge1, r_ge2;
  logic [2:0]       colm, rowm;
  logic [1:0]       ncol, nrow;
  logic             job_cond;

  always_comb begin
    if (width_r == '0)                                  w_last = '0;
    else if ({2'b0, width_r} > CMP_W'(MAX_WIDTH))       w_last = CMP_W'(MAX_WIDTH - 1);
    else                                                w_last = {2'b0, width_r} - 1'b1;
    if (height_r == '0)                                 h_last = '0;
    else if (height_r > CMP_W'(HEIGHT_MAX))             h_last = CMP_W'(HEIGHT_MAX - 1);
    else                                                h_last = height_r - 1'b1;
  end

  assign in_full = !(state_r == F_IN && q_stat.level <= (JOBQ_AW+1)'(JOBQ_DEPTH - JOBS_MAX));
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (accept) begin
      up_q_r  <= upper_mem[col_r];
      mid_q_r <= middle_mem[col_r];
    end
    if (state_r == F_RD) begin
      upper_mem[cur_c_r]  <= mid_q_r;
      middle_mem[cur_c_r] <= px_r;
    end
  end

  assign c_ge1 = (cur_c_r != '0);
  assign c_ge2 = (cur_c_r > CW'(1));
  assign r_ge1 = (cur_y_r != '0);
  assign r_ge2 = (cur_y_r > ROW_W'(1));

  always_comb begin
    colm     = {1'b1, c_ge1, !sel_r[0] && c_ge2};
    rowm     = {1'b1, r_ge1, !sel_r[1] && r_ge2};
    ncol     = 2'(colm[0]) + 2'(colm[1]) + 2'(colm[2]);
    nrow     = 2'(rowm[0]) + 2'(rowm[1]) + 2'(rowm[2]);
    job_cond = (sel_r[1] ? last_row_r : r_ge1) && (sel_r[0] ? end_row_r : c_ge1);
    job_data.sum_red   = '0;
    job_data.sum_green = '0;
    job_data.sum_blue  = '0;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        if (colm[k] && rowm[t]) begin
          job_data.sum_red   = job_data.sum_red   + SUM_W'(win_r[k][t][23:16]);
          job_data.sum_green = job_data.sum_green + SUM_W'(win_r[k][t][15:8]);
          job_data.sum_blue  = job_data.sum_blue  + SUM_W'(win_r[k][t][7:0]);
        end
      end
    end
    job_data.count = {2'b0, ncol} * {2'b0, nrow};
    job_data.last  = (sel_r == 2'd3);
  end

  assign job_push = (state_r == F_EMIT) && job_cond;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IN;
      width_r  <= CFGW_W'(640);
      height_r <= CFGH_W'(480);
      col_r    <= '0;
      row_r    <= '0;
      sel_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= cfg_data[CFGW_W-1:0];
          REG_FRAME_HEIGHT: height_r <= cfg_data[CFGH_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        F_IN: begin
          if (accept) begin
            cur_c_r    <= col_r;
            cur_y_r    <= row_r;
            px_r       <= {in_red, in_green, in_blue};
            end_row_r  <= CMP_W'(col_r) >= w_last;
            last_row_r <= CMP_W'(row_r) >= h_last;
            state_r    <= F_RD;
          end
        end
        F_RD: begin
          for (int k = 0; k < 2; k++) begin
            for (int t = 0; t < 3; t++) begin
              win_r[k][t] <= win_r[k+1][t];
            end
          end
          win_r[2][0] <= up_q_r;
          win_r[2][1] <= mid_q_r;
          win_r[2][2] <= px_r;
          if (end_row_r) begin
            col_r <= '0;
            row_r <= last_row_r ? '0 : cur_y_r + 1'b1;
          end else begin
            col_r <= cur_c_r + 1'b1;
          end
          sel_r   <= '0;
          state_r <= F_EMIT;
        end
        F_EMIT: begin
          sel_r <= sel_r + 1'b1;
          if (sel_r == 2'd3) state_r <= F_IN;
        end
        default: state_r <= F_IN;
      endcase
    end
  end

endmodule

[rtl/bb_back.sv]
// Back end: rounded mean per channel by a bit-serial restoring divider.
module bb_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bb_pkg::job_t            job,
  input  logic                    job_valid,
  output logic                    job_pop,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [bb_pkg::CH_W-1:0] out_blur_red,
  output logic [bb_pkg::CH_W-1:0] out_blur_green,
  output logic [bb_pkg::CH_W-1:0] out_blur_blue,
  output logic                    out_frame_last
);
  import bb_pkg::*;

  typedef enum logic {B_IDLE, B_DIV} bstate_t;

  bstate_t           state_r;
  logic [NUM_W-1:0]  num_r [3];
  logic [DEN_W-1:0]  rem_r [3];
  logic [CH_W-1:0]   quo_r [3];
  logic [DEN_W-1:0]  den_r;
  logic              last_q_r;
  logic [3:0]        step_r;
  logic              out_valid_r;

  logic [NUM_W-1:0]  num_nxt [3];
  logic [DEN_W-1:0]  rem_nxt [3];
  logic [CH_W-1:0]   quo_nxt [3];
  logic [DEN_W:0]    trial;

  always_comb begin
    trial = '0;
    for (int i = 0; i < 3; i++) begin
      trial      = {rem_r[i], num_r[i][NUM_W-1]};
      num_nxt[i] = {num_r[i][NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt[i] = DEN_W'(trial - {1'b0, den_r});
        quo_nxt[i] = {quo_r[i][CH_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[DEN_W-1:0];
        quo_nxt[i] = {quo_r[i][CH_W-2:0], 1'b0};
      end
    end
  end

  assign job_pop   = (state_r == B_IDLE) && job_valid && !out_valid_r;
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (job_pop) begin
            num_r[0] <= {job.sum_red, 1'b0} + NUM_W'(job.count);
            num_r[1] <= {job.sum_green, 1'b0} + NUM_W'(job.count);
            num_r[2] <= {job.sum_blue, 1'b0} + NUM_W'(job.count);
            for (int i = 0; i < 3; i++) begin
              rem_r[i] <= '0;
              quo_r[i] <= '0;
            end
            den_r    <= {job.count, 1'b0};
            last_q_r <= job.last;
            step_r   <= '0;
            state_r  <= B_DIV;
          end
        end
        B_DIV: begin
          for (int i = 0; i < 3; i++) begin
            num_r[i] <= num_nxt[i];
            rem_r[i] <= rem_nxt[i];
            quo_r[i] <= quo_nxt[i];
          end
          step_r <= step_r + 1'b1;
          if (step_r == 4'(NUM_W - 1)) begin
            out_blur_red   <= quo_nxt[0];
            out_blur_green <= quo_nxt[1];
            out_blur_blue  <= quo_nxt[2];
            out_frame_last <= last_q_r;
            out_valid_r    <= 1'b1;
            state_r        <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

[sim/box_blur_3x3_rgb_tb.sv]
// Testbench for box_blur_3x3_rgb: directed table and random frames against a built-in predictor.
module box_blur_3x3_rgb_tb;
  import bb_pkg::*;

  localparam int LINE_LEN   = 1024;
  localparam int IDLE_WAIT  = 200;
  localparam int LONG_HOLD  = 2000;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } blur_t;

  typedef struct {
    int              fw;
    int              fh;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    bit              typed;
    blur_t           want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [CH_W-1:0]       in_red, in_green, in_blue;
  logic                  out_empty;
  logic                  out_pop;
  logic [CH_W-1:0]       out_blur_red, out_blur_green, out_blur_blue;
  logic                  out_frame_last;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_blur_3x3_rgb i_dut (.*);

  // predictor state
  pixel_t upper_q[LINE_LEN];
  pixel_t middle_q[LINE_LEN];
  pixel_t win[9];
  int     col_pos, row_pos;
  int     width_reg, height_reg;

  blur_t  blur_q[$];
  blur_t  step_q[$];
  int     errors;
  int     items;
  bit     hold_req;
  bit     hold_started;
  int     hold_cnt;

  stim_row_t dir_tab[$];

  initial begin
    clk = 1'b0;
    forever begin
      #2 clk = 1'b1;
      #2 clk = 1'b0;
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic void blur_center(int y, int x, int r, int c, int lastr, int lastc,
                                      bit last);
    int    sr, sg, sb, cnt, cl, rw;
    blur_t res;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int k = 0; k < 3; k++) begin
      cl = c - 2 + k;
      if (cl < 0 || cl > lastc || cl < x - 1 || cl > x + 1) continue;
      for (int t = 0; t < 3; t++) begin
        rw = r - 2 + t;
        if (rw < 0 || rw > lastr || rw < y - 1 || rw > y + 1) continue;
        sr += win[k*3+t][23:16];
        sg += win[k*3+t][15:8];
        sb += win[k*3+t][7:0];
        cnt++;
      end
    end
    res.red   = CH_W'((2*sr + cnt) / (2*cnt));
    res.green = CH_W'((2*sg + cnt) / (2*cnt));
    res.blue  = CH_W'((2*sb + cnt) / (2*cnt));
    res.last  = last;
    step_q.push_back(res);
  endfunction

  function automatic void blur_pixel(pixel_t px);
    int     w, h, c, r, lastc, lastr;
    bit     end_row, last_row;
    pixel_t up, mid;
    w = (width_reg < 1) ? 1 : (width_reg > LINE_LEN ? LINE_LEN : width_reg);
    h = (height_reg < 1) ? 1 : (height_reg > HEIGHT_MAX ? HEIGHT_MAX : height_reg);
    c = col_pos;
    r = row_pos;
    up = upper_q[c];
    mid = middle_q[c];
    upper_q[c] = mid;
    middle_q[c] = px;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = up;
    win[7] = mid;
    win[8] = px;
    end_row  = (c >= w - 1);
    last_row = (r >= h - 1);
    lastc = end_row ? c : w - 1;
    lastr = last_row ? r : h - 1;
    step_q.delete();
    if (r >= 1) begin
      if (c >= 1) blur_center(r-1, c-1, r, c, lastr, lastc, 1'b0);
      if (end_row) blur_center(r-1, c, r, c, lastr, lastc, 1'b0);
    end
    if (last_row) begin
      if (c >= 1) blur_center(r, c-1, r, c, lastr, lastc, 1'b0);
      if (end_row) blur_center(r, c, r, c, lastr, lastc, 1'b1);
    end
    if (end_row) begin
      col_pos = 0;
      row_pos = (end_row && last_row) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic idle_gap();
    int sel, n;
    sel = $urandom_range(99);
    if (sel < 65) n = 0;
    else if (sel < 95) n = $urandom_range(3, 1);
    else n = $urandom_range(40, 10);
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                            bit typed, blur_t want);
    in_push  <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_full !== 1'b0);
    blur_pixel({r, g, b});
    if (typed) blur_q.push_back(want);
    else foreach (step_q[i]) blur_q.push_back(step_q[i]);
    items++;
    idle_gap();
  endtask

  task automatic drain();
    in_push <= 1'b0;
    wait (blur_q.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic set_size(int w, int h);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_reg  = w & 12'h7ff;
    height_reg = h & 16'h1fff;
  endtask

  task automatic send_frames(int w, int h, int frames);
    int ew, eh;
    blur_t none;
    none = '{default: '0};
    ew = (w < 1) ? 1 : (w > LINE_LEN ? LINE_LEN : w);
    eh = (h < 1) ? 1 : h;
    repeat (frames * ew * eh)
      send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                 CH_W'($urandom_range(255)), 1'b0, none);
  endtask

  function automatic stim_row_t mk(int fw, int fh, int r, int g, int b, bit typed, bit last);
    stim_row_t s;
    s.fw = fw; s.fh = fh;
    s.red = CH_W'(r); s.green = CH_W'(g); s.blue = CH_W'(b);
    s.typed = typed;
    s.want = '{red: CH_W'(r), green: CH_W'(g), blue: CH_W'(b), last: last};
    return s;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (blur_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h %h last=%b", out_blur_red,
                                   out_blur_green, out_blur_blue, out_frame_last);
      end else begin
        blur_t e;
        e = blur_q.pop_front();
        if (out_blur_red !== e.red || out_blur_green !== e.green ||
            out_blur_blue !== e.blue || out_frame_last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want %h %h %h last=%b, got %h %h %h last=%b",
                     e.red, e.green, e.blue, e.last, out_blur_red, out_blur_green,
                     out_blur_blue, out_frame_last);
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_cnt = LONG_HOLD;
      out_pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_pop <= 1'b0;
    end else begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) out_pop <= 1'b1;
      else if (sel < 97) out_pop <= 1'b0;
      else begin
        hold_cnt = $urandom_range(40, 10);
        out_pop <= 1'b0;
      end
    end
  end

  initial begin
    int fw_prev, fh_prev, w, h;
    blur_t none;
    none = '{default: '0};
    errors = 0; items = 0;
    hold_req = 1'b0; hold_started = 1'b0; hold_cnt = 0;
    rst_n = 1'b0; in_push = 1'b0;
    in_red = '0; in_green = '0; in_blue = '0;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
    width_reg = 640; height_reg = 480;
    col_pos = 0; row_pos = 0;
    foreach (win[i]) win[i] = '0;
    foreach (upper_q[i]) begin
      upper_q[i] = '0;
      middle_q[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero sizes act as a 1x1 frame: each pixel blurs to itself
    dir_tab.push_back(mk(0, 0, 8'h00, 8'h00, 8'h00, 1, 1));
    dir_tab.push_back(mk(0, 0, 8'hff, 8'hff, 8'hff, 1, 1));
    dir_tab.push_back(mk(0, 0, 8'hff, 8'h00, 8'h00, 1, 1));
    dir_tab.push_back(mk(0, 0, 8'h00, 8'hff, 8'h00, 1, 1));
    dir_tab.push_back(mk(0, 0, 8'h00, 8'h00, 8'hff, 1, 1));
    dir_tab.push_back(mk(0, 0, 8'haa, 8'h55, 8'h01, 1, 1));
    dir_tab.push_back(mk(0, 0, 8'h80, 8'h7f, 8'hfe, 1, 1));
    // 2x2: corners only, half-up rounding
    dir_tab.push_back(mk(2, 2, 8'hff, 8'h00, 8'h01, 0, 0));
    dir_tab.push_back(mk(2, 2, 8'h00, 8'hff, 8'h00, 0, 0));
    dir_tab.push_back(mk(2, 2, 8'h00, 8'h00, 8'h00, 0, 0));
    dir_tab.push_back(mk(2, 2, 8'h01, 8'hff, 8'h01, 0, 0));
    // 3x3: corners, edges and one interior pixel
    for (int i = 0; i < 9; i++)
      dir_tab.push_back(mk(3, 3, (i % 2) ? 8'hff : 8'h00, i * 31, 255 - i * 17, 0, 0));

    fw_prev = -1; fh_prev = -1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].fw != fw_prev || dir_tab[i].fh != fh_prev) begin
        set_size(dir_tab[i].fw, dir_tab[i].fh);
        fw_prev = dir_tab[i].fw;
        fh_prev = dir_tab[i].fh;
      end
      send_pixel(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue, dir_tab[i].typed,
                 dir_tab[i].want);
    end

    set_size(1, 5);
    send_frames(1, 5, 1);
    set_size(6, 1);
    send_frames(6, 1, 1);

    // long receiver hold while the sender keeps pushing
    set_size(8, 6);
    hold_req = 1'b1;
    send_frames(8, 6, 1);

    while (items < 340) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 1);
      h = ($urandom_range(9) == 0) ? 1 : $urandom_range(7, 2);
      set_size(w, h);
      send_frames(w, h, $urandom_range(2, 1));
      if ($urandom_range(7) == 0) drain();
    end

    // height saturated: the frame never closes, two rows and a bit
    set_size(3, 8191);
    repeat (7)
      send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                 CH_W'($urandom_range(255)), 1'b0, none);

    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
